### rtl/core/wsd_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Parse phases, header constants and the result record shared by the stages.
// ----------------------------------------------------------------------------
package wsd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT16   = 3'd2,
        PH_EXT64   = 3'd3,
        PH_KEY     = 3'd4,
        PH_PAYLOAD = 3'd5
    } phase_t;

    localparam logic [6:0] LEN7_EXT16    = 7'd126;
    localparam logic [6:0] LEN7_EXT64    = 7'd127;
    localparam logic [2:0] EXT16_BYTES   = 3'd2;
    localparam logic [2:0] EXT64_WRAP    = 3'd0;
    localparam logic [2:0] KEY_BYTES     = 3'd4;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic [3:0] frame_opcode;
        logic       frame_end;
        logic       message_end;
    } result_t;

endpackage

### rtl/core/wsd_in_reg.sv
// ----------------------------------------------------------------------------
// Input register
// Holds one received stream byte until the parser takes it.
// ----------------------------------------------------------------------------
module wsd_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] stream_byte,
    input  logic       stream_valid,
    output logic       stream_stall,
    input  logic       take,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       load;

    // A held byte blocks the port unless the parser consumes it this cycle.
    assign stream_stall = valid_reg && !take;
    assign load         = stream_valid && !stream_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= stream_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

### rtl/core/wsd_parse.sv
// ----------------------------------------------------------------------------
// Frame parser
// Header, extended length and key tracking, payload unmasking, frame end flags.
// ----------------------------------------------------------------------------
module wsd_parse #(
    parameter int LENGTH_BITS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [7:0]        in_byte,
    output logic              has_result,
    output wsd_pkg::result_t  result
);

    wsd_pkg::phase_t         phase_reg;
    wsd_pkg::phase_t         phase_next;
    logic [3:0]              opcode_reg;
    logic [3:0]              opcode_next;
    logic                    fin_reg;
    logic                    fin_next;
    logic                    masked_reg;
    logic                    masked_next;
    logic [2:0]              count_reg;
    logic [2:0]              count_next;
    logic [LENGTH_BITS-1:0]  len_reg;
    logic [LENGTH_BITS-1:0]  len_next;
    logic [31:0]             key_reg;
    logic [31:0]             key_next;
    logic [1:0]              offset_reg;
    logic [1:0]              offset_next;

    always_comb
    begin
        logic                   do_after;
        logic                   after_masked;
        logic                   do_finish;
        logic [LENGTH_BITS-1:0] fin_len;
        logic [LENGTH_BITS-1:0] len_shift;
        logic [2:0]             count_inc;
        logic [7:0]             key_byte;
        logic                   last;

        phase_next   = phase_reg;
        opcode_next  = opcode_reg;
        fin_next     = fin_reg;
        masked_next  = masked_reg;
        count_next   = count_reg;
        len_next     = len_reg;
        key_next     = key_reg;
        offset_next  = offset_reg;

        do_after     = 1'b0;
        after_masked = masked_reg;
        do_finish    = 1'b0;
        fin_len      = len_reg;
        len_shift    = {len_reg[LENGTH_BITS-9:0], in_byte};
        count_inc    = count_reg + 3'd1;
        key_byte     = 8'd0;
        last         = 1'b0;

        has_result          = 1'b0;
        result.payload_byte = 8'd0;
        result.byte_valid   = 1'b0;
        result.frame_opcode = opcode_reg;
        result.frame_end    = 1'b0;
        result.message_end  = 1'b0;

        unique case (phase_reg)
            wsd_pkg::PH_HDR0:
            begin
                opcode_next = in_byte[3:0];
                fin_next    = in_byte[7];
                phase_next  = wsd_pkg::PH_HDR1;
            end
            wsd_pkg::PH_HDR1:
            begin
                masked_next  = in_byte[7];
                after_masked = in_byte[7];
                key_next     = 32'd0;
                count_next   = 3'd0;
                if (in_byte[6:0] == wsd_pkg::LEN7_EXT16)
                begin
                    len_next   = '0;
                    phase_next = wsd_pkg::PH_EXT16;
                end
                else if (in_byte[6:0] == wsd_pkg::LEN7_EXT64)
                begin
                    len_next   = '0;
                    phase_next = wsd_pkg::PH_EXT64;
                end
                else
                begin
                    len_next = {{(LENGTH_BITS-7){1'b0}}, in_byte[6:0]};
                    fin_len  = {{(LENGTH_BITS-7){1'b0}}, in_byte[6:0]};
                    do_after = 1'b1;
                end
            end
            wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64:
            begin
                // Big-endian accumulation; the upper bits fall off on narrow builds.
                len_next   = len_shift;
                count_next = count_inc;
                fin_len    = len_shift;
                if ((phase_reg == wsd_pkg::PH_EXT16 && count_inc == wsd_pkg::EXT16_BYTES) ||
                    (phase_reg == wsd_pkg::PH_EXT64 && count_inc == wsd_pkg::EXT64_WRAP))
                begin
                    do_after = 1'b1;
                end
            end
            wsd_pkg::PH_KEY:
            begin
                key_next   = {key_reg[23:0], in_byte};
                count_next = count_inc;
                if (count_inc >= wsd_pkg::KEY_BYTES)
                begin
                    count_next = 3'd0;
                    do_finish  = 1'b1;
                end
            end
            wsd_pkg::PH_PAYLOAD:
            begin
                unique case (offset_reg)
                    2'd0: key_byte = key_reg[31:24];
                    2'd1: key_byte = key_reg[23:16];
                    2'd2: key_byte = key_reg[15:8];
                    2'd3: key_byte = key_reg[7:0];
                    default: key_byte = 8'd0;
                endcase
                // The length register counts down the bytes still to come.
                last        = (len_reg == {{(LENGTH_BITS-1){1'b0}}, 1'b1});
                len_next    = len_reg - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
                offset_next = offset_reg + 2'd1;
                has_result          = 1'b1;
                result.payload_byte = in_byte ^ key_byte;
                result.byte_valid   = 1'b1;
                result.frame_end    = last;
                result.message_end  = last && fin_reg;
                if (last)
                begin
                    phase_next  = wsd_pkg::PH_HDR0;
                    offset_next = 2'd0;
                end
            end
            default:
            begin
                phase_next = wsd_pkg::PH_HDR0;
            end
        endcase

        if (do_after)
        begin
            count_next = 3'd0;
            if (after_masked)
            begin
                phase_next = wsd_pkg::PH_KEY;
            end
            else
            begin
                do_finish = 1'b1;
            end
        end

        if (do_finish)
        begin
            offset_next = 2'd0;
            if (fin_len == '0)
            begin
                // An empty frame ends on its last header byte with a data-less result.
                phase_next         = wsd_pkg::PH_HDR0;
                has_result         = 1'b1;
                result.frame_end   = 1'b1;
                result.message_end = fin_reg;
            end
            else
            begin
                phase_next = wsd_pkg::PH_PAYLOAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= wsd_pkg::PH_HDR0;
            opcode_reg <= 4'd0;
            fin_reg    <= 1'b0;
            masked_reg <= 1'b0;
            count_reg  <= 3'd0;
            len_reg    <= '0;
            key_reg    <= 32'd0;
            offset_reg <= 2'd0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            fin_reg    <= fin_next;
            masked_reg <= masked_next;
            count_reg  <= count_next;
            len_reg    <= len_next;
            key_reg    <= key_next;
            offset_reg <= offset_next;
        end
    end

endmodule

### rtl/core/wsd_out_reg.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one parsed result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module wsd_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  wsd_pkg::result_t  load_result,
    output logic              slot_free,
    output logic              result_valid,
    input  logic              result_stall,
    output wsd_pkg::result_t  held_result
);

    logic             valid_reg;
    logic             valid_next;
    wsd_pkg::result_t result_reg;

    assign slot_free = !valid_reg || !result_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign result_valid = valid_reg;
    assign held_result  = result_reg;

endmodule

### rtl/core/websocket_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses framed stream bytes and delivers unmasked payload bytes with frame flags.
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock unless stalled and gives at most one
// result per byte: payload bytes come out unmasked and tagged with the frame
// opcode, the last one marked with frame_end and, for a final frame, message_end;
// an empty frame yields a single data-less result on its last header byte. A byte
// needs one pass through the parser between the input register and the result
// register, so the sustained rate is one byte per cycle while result_stall is low,
// and a result is presented on the cycle after its byte is taken. Header bytes
// keep flowing while a result waits downstream; only a byte that produces a result
// waits for the result register to empty. LENGTH_BITS (16 to 64) sets the width
// of the kept frame length; longer lengths wrap to its low bits.
module websocket_frame_deframer_top #(
    parameter int LENGTH_BITS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] stream_byte,
    input  logic       stream_valid,
    output logic       stream_stall,
    output logic [7:0] payload_byte,
    output logic       byte_valid,
    output logic [3:0] frame_opcode,
    output logic       frame_end,
    output logic       message_end,
    output logic       result_valid,
    input  logic       result_stall
);

    logic             held_valid;
    logic [7:0]       held_byte;
    logic             take;
    logic             has_result;
    logic             slot_free;
    wsd_pkg::result_t parse_result;
    wsd_pkg::result_t out_result;

    // A byte without a result never waits on the downstream side.
    assign take = held_valid && (!has_result || slot_free);

    wsd_in_reg u_in_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .stream_byte  (stream_byte),
        .stream_valid (stream_valid),
        .stream_stall (stream_stall),
        .take         (take),
        .held_valid   (held_valid),
        .held_byte    (held_byte)
    );

    wsd_parse #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (take),
        .in_byte    (held_byte),
        .has_result (has_result),
        .result     (parse_result)
    );

    wsd_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (take && has_result),
        .load_result  (parse_result),
        .slot_free    (slot_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .held_result  (out_result)
    );

    assign payload_byte = out_result.payload_byte;
    assign byte_valid   = out_result.byte_valid;
    assign frame_opcode = out_result.frame_opcode;
    assign frame_end    = out_result.frame_end;
    assign message_end  = out_result.message_end;

endmodule
